/* hdl/mrs_pkg.sv */
// Shared constants and types for the modular squaring generator step.
// Used by mrs_mul, mrs_core and modular_square_rng_step; no dependencies.
package mrs_pkg;

  localparam int VALUE_W = 30;
  localparam int MUL_W   = 32;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int TDATA_W = 32;

  localparam longint unsigned PRIME_P = 64'd10007;
  localparam longint unsigned PRIME_Q = 64'd100003;
  localparam longint unsigned MODULUS_L = PRIME_P * PRIME_Q;
  // Barrett factor floor(2^60 / M), fits in 31 bits
  localparam longint unsigned MU_L = (64'd1 << 60) / MODULUS_L;

  localparam logic [MUL_W-1:0] MODULUS   = MUL_W'(MODULUS_L);
  localparam logic [MUL_W-1:0] MU        = MUL_W'(MU_L);
  localparam logic [MUL_W-1:0] THRESHOLD = MUL_W'(64'd1000000000);

  localparam int MAX_SQUARINGS_DEF = 64;

  typedef struct packed {
    logic [VALUE_W-1:0] next_value;
    logic               gave_up;
  } mrs_result_t;

endpackage

/* hdl/mrs_mul.sv */
// Shared 32x32 multiplier with registered product.
// Depends on mrs_pkg for operand and product widths.
module mrs_mul (
  input  logic                      clk,
  input  logic [mrs_pkg::MUL_W-1:0] a,
  input  logic [mrs_pkg::MUL_W-1:0] b,
  output logic [mrs_pkg::PROD_W-1:0] p
);
  import mrs_pkg::*;

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

/* hdl/mrs_core.sv */
// Sequencer for the square-and-reduce loop around one shared multiplier.
// Depends on mrs_pkg and mrs_mul; Barrett reduction modulo the fixed modulus.
module mrs_core #(
  parameter int MAX_SQUARINGS = mrs_pkg::MAX_SQUARINGS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mrs_pkg::VALUE_W-1:0] seed,
  output logic                        idle,
  output logic                        res_valid,
  input  logic                        res_ready,
  output mrs_pkg::mrs_result_t        result
);
  import mrs_pkg::*;

  localparam int TRY_W = (MAX_SQUARINGS > 1) ? $clog2(MAX_SQUARINGS) : 1;
  localparam logic [TRY_W-1:0] LAST_TRY = TRY_W'(MAX_SQUARINGS - 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SQUARE = 7'b0000010,
    S_QUOT   = 7'b0000100,
    S_REMN   = 7'b0001000,
    S_SUB    = 7'b0010000,
    S_FIX    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state;
  logic [VALUE_W-1:0] x;
  logic [TRY_W-1:0]   tries;
  logic [MUL_W-1:0]   sq_lo;
  logic [MUL_W-1:0]   r;
  logic [MUL_W-1:0]   r_over;
  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [PROD_W-1:0]  p;

  mrs_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  // operand select: square, then q1*mu, then q3*M
  always_comb begin
    unique case (state)
      S_QUOT: begin
        mul_a = {1'b0, p[59:29]};
        mul_b = MU;
      end
      S_REMN: begin
        mul_a = {1'b0, p[61:31]};
        mul_b = MODULUS;
      end
      default: begin
        mul_a = MUL_W'(x);
        mul_b = MUL_W'(x);
      end
    endcase
  end

  assign r_over    = r - THRESHOLD;
  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            x     <= seed;
            tries <= '0;
            state <= S_SQUARE;
          end
        end
        S_SQUARE: state <= S_QUOT;
        S_QUOT: begin
          sq_lo <= p[MUL_W-1:0];
          state <= S_REMN;
        end
        S_REMN: state <= S_SUB;
        S_SUB: begin
          // Barrett remainder, below 3M so it fits in 32 bits
          r     <= sq_lo - p[MUL_W-1:0];
          state <= S_FIX;
        end
        S_FIX: begin
          if (r >= MODULUS) begin
            r <= r - MODULUS;
          end else if (r < THRESHOLD) begin
            result.next_value <= r[VALUE_W-1:0];
            result.gave_up    <= 1'b0;
            state             <= S_DONE;
          end else if (tries == LAST_TRY) begin
            result.next_value <= r_over[VALUE_W-1:0];
            result.gave_up    <= 1'b1;
            state             <= S_DONE;
          end else begin
            x     <= r[VALUE_W-1:0];
            tries <= tries + TRY_W'(1);
            state <= S_SQUARE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/modular_square_rng_step.sv */
// Per squaring the core steps through square, two Barrett multiplies, subtract, compare
// and up to two corrections; its done state then hands the result into the output register.
// Throughput: one beat at a time, set by the single shared multiplier; a new beat is
// taken only after the core is idle again, which m_tready stalls can delay.
// Reset (rst, synchronous, active high) empties the output register and
// returns the sequencer to idle; no other state is kept between beats.
module modular_square_rng_step #(
  parameter int MAX_SQUARINGS = mrs_pkg::MAX_SQUARINGS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mrs_pkg::TDATA_W-1:0]   s_tdata,  // [29:0] seed, [31:30] zero
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mrs_pkg::TDATA_W-1:0]   m_tdata,  // [29:0] next_value, [31:30] zero
  output logic                          m_tuser   // [0] gave_up
);
  import mrs_pkg::*;

  logic        core_idle;
  logic        res_valid;
  logic        res_ready;
  mrs_result_t result;
  mrs_result_t out_q;

  // the core only takes a seed when it has nothing in flight
  assign s_tready = core_idle;

  // output register frees the core once a result is parked here
  assign res_ready = !m_tvalid || m_tready;

  mrs_core #(
    .MAX_SQUARINGS (MAX_SQUARINGS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (s_tvalid && s_tready),
    .seed      (s_tdata[VALUE_W-1:0]),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= result;
    end
  end

  assign m_tdata = TDATA_W'(out_q.next_value);
  assign m_tuser = out_q.gave_up;

endmodule

/* bench/modular_square_rng_step_test.sv */
// Testbench for modular_square_rng_step: drives seeds over the slave stream, predicts each
// squaring result and checks every master beat against it; depends on mrs_pkg and the RTL.
module modular_square_rng_step_test;
  import mrs_pkg::*;

  localparam int SQUARINGS = 64;
  localparam longint unsigned SQ_MODULUS = 64'd10007 * 64'd100003;
  localparam longint unsigned BELOW = 64'd1000000000;
  // worst case per beat: every try plus the output register, with some slack
  localparam int TAIL_CYCLES = 8 * SQUARINGS + 16;
  localparam int LIMIT_CYCLES = 4000000;
  localparam int PHASE_BEATS = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;  // [29:0] seed, [31:30] zero
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;  // [29:0] next_value, [31:30] zero
  logic m_tuser;  // [0] gave_up

  mrs_result_t pending_results[$];
  int mismatches = 0;
  int cycle_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  logic [VALUE_W-1:0] chain_value = '0;

  modular_square_rng_step #(
    .MAX_SQUARINGS(SQUARINGS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Square modulo p*q until the residue drops below one billion, or give up
  function automatic mrs_result_t square_until_below(logic [VALUE_W-1:0] seed);
    longint unsigned residue;
    mrs_result_t res;
    residue = seed;
    res.next_value = '0;
    res.gave_up = 1'b1;
    for (int i = 0; i < SQUARINGS; i++) begin
      residue = (residue * residue) % SQ_MODULUS;
      if (residue < BELOW) begin
        res.next_value = VALUE_W'(residue);
        res.gave_up = 1'b0;
        return res;
      end
    end
    // out of tries: last residue folded below the threshold
    res.next_value = VALUE_W'(residue % BELOW);
    return res;
  endfunction

  // Result side: random back-pressure, every beat checked against the oldest prediction
  always @(posedge clk) begin
    mrs_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no prediction waiting: next_value %0d gave_up %0b",
                 m_tdata[VALUE_W-1:0], m_tuser);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[VALUE_W-1:0] !== want.next_value) begin
            $error("next_value: expected %0d, got %0d", want.next_value,
                   m_tdata[VALUE_W-1:0]);
            mismatches++;
          end
          if (m_tuser !== want.gave_up) begin
            $error("gave_up: expected %0b, got %0b", want.gave_up, m_tuser);
            mismatches++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // One seed beat, with random idle cycles ahead of it; returns at the accepting edge
  task automatic send_seed(logic [VALUE_W-1:0] seed);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(TDATA_W - VALUE_W){1'b0}}, seed};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(square_until_below(seed));
    chain_value = pending_results[$].next_value;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Extremes, the retry window around sqrt(1e9), idempotents, seeds at and above M
  task automatic test_edge_seeds();
    logic [VALUE_W-1:0] seeds[$];
    idle_pct = 0;
    stall_pct = 0;
    seeds = '{30'd0, 30'd1, 30'd2, 30'd31622, 30'd31623, 30'd31628, 30'd31634, 30'd31635,
              30'd209106273, 30'd791623749, 30'd999999999, 30'd1000000000,
              30'd1000730020, 30'd1000730021, 30'd1000730022, 30'h3FFFFFFF,
              30'h2AAAAAAA, 30'h15555555};
    foreach (seeds[i]) send_seed(seeds[i]);
  endtask

  // Mostly chained runs as the generator is meant to be used, some raw 30-bit noise
  task automatic test_chained_runs(int beats, int idle, int stall);
    int run_left;
    logic [VALUE_W-1:0] seed;
    idle_pct = idle;
    stall_pct = stall;
    run_left = 0;
    for (int n = 0; n < beats; n++) begin
      if (run_left > 0) begin
        seed = chain_value;
        run_left--;
      end else if ($urandom_range(99) < 15) begin
        seed = VALUE_W'($urandom);
      end else if ($urandom_range(99) < 10) begin
        // land in the window whose square needs a second try
        seed = VALUE_W'($urandom_range(31634, 31623));
        run_left = $urandom_range(24, 4);
      end else begin
        seed = VALUE_W'($urandom_range(999999999));
        run_left = $urandom_range(24, 4);
      end
      send_seed(seed);
    end
  endtask

  // Sender holds off until every outstanding result has been taken
  task automatic test_drain_pauses();
    idle_pct = 0;
    stall_pct = 51;
    for (int k = 0; k < 3; k++) begin
      for (int n = 0; n < 12; n++) send_seed(VALUE_W'($urandom_range(999999999)));
      s_tvalid <= 1'b0;
      wait_drained();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edge_seeds();
    test_chained_runs(PHASE_BEATS, 0, 0);
    test_chained_runs(PHASE_BEATS, 51, 0);
    test_chained_runs(PHASE_BEATS, 0, 51);
    test_chained_runs(PHASE_BEATS, 30, 30);
    test_drain_pauses();
    s_tvalid <= 1'b0;
    wait_drained();
    // catch any stray beat after the last prediction is met
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/mrs_pkg.sv
hdl/mrs_mul.sv
hdl/mrs_core.sv
hdl/modular_square_rng_step.sv
bench/modular_square_rng_step_test.sv
